>>> hdl/mrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrr_pkg;

   localparam int FRAME_LEN   = 9;
   localparam int MIN_LEN     = 5;
   localparam int VIEW_LEN    = 7;
   localparam int COUNT_W     = 8;
   localparam int SIL_W       = 17;
   localparam int ELAP_W      = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int STORE_IDX_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
   localparam int EXC_BIT_POS = 7;

   localparam logic [COUNT_W-1:0] FRAME_LEN_CNT = COUNT_W'(FRAME_LEN);
   localparam logic [COUNT_W-1:0] MIN_LEN_CNT   = COUNT_W'(MIN_LEN);
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
   localparam logic [SIL_W-1:0]   SIL_MAX       = '1;
   localparam logic [ELAP_W-1:0]  ELAP_MAX      = '1;
   localparam logic [15:0]        CRC_SEED      = 16'hFFFF;
   localparam logic [15:0]        CRC_POLY      = 16'hA001;
   localparam logic [7:0]         WANT_COUNT    = 8'd4;

   localparam logic [7:0]        RST_SLAVE_ADDRESS = 8'd1;
   localparam logic [7:0]        RST_FUNCTION_CODE = 8'd3;
   localparam logic [SIL_W-1:0]  RST_SILENCE_TICKS = SIL_W'(1750);
   localparam logic [ELAP_W-1:0] RST_TIMEOUT_TICKS = ELAP_W'(100000);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLAVE_ADDRESS = 2'd0,
      CSR_FUNCTION_CODE = 2'd1,
      CSR_SILENCE_TICKS = 2'd2,
      CSR_TIMEOUT_TICKS = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INCOMPLETE = 3'd1,
      ST_TOO_LONG   = 3'd2,
      ST_ADDRESS    = 3'd3,
      ST_CRC        = 3'd4,
      ST_EXCEPTION  = 3'd5,
      ST_FUNCTION   = 3'd6,
      ST_BYTE_COUNT = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0]        slave_address;
      logic [7:0]        function_code;
      logic [SIL_W-1:0]  silence_ticks;
      logic [ELAP_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        reg_value;
      logic [7:0]         exception_code;
      logic [COUNT_W-1:0] frame_length;
      logic               timed_out;
   } result_type;

   typedef logic [VIEW_LEN-1:0][7:0] view_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mrr_csr_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module mrr_csr_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [mrr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mrr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mrr_pkg::cfg_type                     cfg
);
   import mrr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS: cfg_in.slave_address = csr_wdata[7:0];
            CSR_FUNCTION_CODE: cfg_in.function_code = csr_wdata[7:0];
            CSR_SILENCE_TICKS: cfg_in.silence_ticks = csr_wdata[SIL_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[ELAP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= RST_SLAVE_ADDRESS;
         cfg_ff.function_code <= RST_FUNCTION_CODE;
         cfg_ff.silence_ticks <= RST_SILENCE_TICKS;
         cfg_ff.timeout_ticks <= RST_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/mrr_frame_check.sv
`timescale 1ns / 1ps
`default_nettype none

module mrr_frame_check (
   input  wire logic [mrr_pkg::COUNT_W-1:0] frame_count,
   input  wire logic [15:0]                 crc,
   input  wire mrr_pkg::view_type           view,
   input  wire mrr_pkg::cfg_type            cfg,
   input  wire logic                        timed_out,
   output mrr_pkg::result_type              result
);
   import mrr_pkg::*;

   always_comb begin
      result                = '0;
      result.frame_length   = frame_count;
      result.timed_out      = timed_out;
      priority if (frame_count < MIN_LEN_CNT) begin
         result.status = ST_INCOMPLETE;
      end else if (frame_count > FRAME_LEN_CNT) begin
         result.status = ST_TOO_LONG;
      end else if (view[0] != cfg.slave_address) begin
         result.status = ST_ADDRESS;
      end else if (crc != 16'h0000) begin
         result.status = ST_CRC;
      end else if (view[1][EXC_BIT_POS]) begin
         result.status         = ST_EXCEPTION;
         result.exception_code = view[2];
      end else if (frame_count != FRAME_LEN_CNT) begin
         result.status = ST_INCOMPLETE;
      end else if (view[1] != cfg.function_code) begin
         result.status = ST_FUNCTION;
      end else if (view[2] != WANT_COUNT) begin
         result.status = ST_BYTE_COUNT;
      end else begin
         result.status    = ST_OK;
         result.reg_value = {view[3], view[4], view[5], view[6]};
      end
   end

endmodule

`default_nettype wire

>>> hdl/mrr_frame_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module mrr_frame_engine (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [1:0]     opcode,
   input  wire logic [7:0]     rx_byte,
   input  wire mrr_pkg::cfg_type cfg,
   output logic                close_valid,
   output mrr_pkg::result_type result
);
   import mrr_pkg::*;

   logic [7:0]         store_ff [FRAME_LEN];
   logic               store_we;
   logic               receiving_ff, receiving_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [SIL_W-1:0]   sil_ff, sil_in;
   logic [ELAP_W-1:0]  elap_ff, elap_in;

   logic [SIL_W-1:0]   sil_inc;
   logic [ELAP_W-1:0]  elap_inc;
   logic               timed_out;
   view_type           view;

   assign sil_inc  = (sil_ff != SIL_MAX) ? sil_ff + SIL_W'(1) : sil_ff;
   assign elap_inc = (elap_ff != ELAP_MAX) ? elap_ff + ELAP_W'(1) : elap_ff;

   always_comb begin
      receiving_in = receiving_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      sil_in       = sil_ff;
      elap_in      = elap_ff;
      store_we     = 1'b0;
      close_valid  = 1'b0;
      timed_out    = 1'b0;
      if (step) begin
         unique case (opcode)
            OP_START: begin
               receiving_in = 1'b1;
               count_in     = '0;
               crc_in       = CRC_SEED;
               sil_in       = '0;
               elap_in      = '0;
            end
            OP_BYTE: begin
               if (receiving_ff) begin
                  store_we = (count_ff < FRAME_LEN_CNT);
                  count_in = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
                  crc_in   = crc16_byte(crc_ff, rx_byte);
                  sil_in   = '0;
               end
            end
            OP_TICK: begin
               if (receiving_ff) begin
                  elap_in = elap_inc;
                  if (count_ff != '0) begin
                     sil_in = sil_inc;
                  end
                  if ((count_ff != '0) && (sil_inc >= cfg.silence_ticks)) begin
                     close_valid = 1'b1;
                  end else if (elap_inc >= cfg.timeout_ticks) begin
                     close_valid = 1'b1;
                     timed_out   = 1'b1;
                  end
                  if (close_valid) begin
                     receiving_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= CRC_SEED;
         sil_ff       <= '0;
         elap_ff      <= '0;
      end else begin
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         sil_ff       <= sil_in;
         elap_ff      <= elap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[STORE_IDX_W-1:0]] <= rx_byte;
      end
   end

   for (genvar i = 0; i < VIEW_LEN; i++) begin : g_view
      if (i < FRAME_LEN) begin : g_stored
         assign view[i] = store_ff[i];
      end else begin : g_blank
         assign view[i] = '0;
      end
   end

   mrr_frame_check u_check (
      .frame_count (count_ff),
      .crc         (crc_ff),
      .view        (view),
      .cfg         (cfg),
      .timed_out   (timed_out),
      .result      (result)
   );

endmodule

`default_nettype wire

>>> hdl/modbus_rtu_response_receiver.sv
// Modbus RTU reply receiver. Items go req_ -> input register -> frame engine -> rsp_ register,
// one item per cycle with no bubbles unless rsp_ stalls; a closing tick passes the input and
// rsp_ registers to reach rsp_valid. A result held on rsp_ while rsp_ready is low stalls the
// engine, and the input register still takes one more item in that time. An item that closes
// the frame (silence or timeout tick) gives one result; all other items give none. Configuration
// writes on csr_ take effect on the next cycle and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [7:0]                      req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [31:0]                          rsp_reg_value,
   output logic [7:0]                           rsp_exception_code,
   output logic [7:0]                           rsp_frame_length,
   output logic                                 rsp_timed_out,
   input  wire logic                            csr_we,
   input  wire logic [mrr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mrr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mrr_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic [1:0] opcode_ff;
   logic [7:0] rx_byte_ff;
   logic       advance;
   logic       step;
   logic       close_valid;
   result_type result;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   mrr_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mrr_frame_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .opcode      (opcode_ff),
      .rx_byte     (rx_byte_ff),
      .cfg         (cfg),
      .close_valid (close_valid),
      .result      (result)
   );

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? step && close_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         opcode_ff  <= req_opcode;
         rx_byte_ff <= req_rx_byte;
      end
      if (step && close_valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_reg_value      = out_ff.reg_value;
   assign rsp_exception_code = out_ff.exception_code;
   assign rsp_frame_length   = out_ff.frame_length;
   assign rsp_timed_out      = out_ff.timed_out;

endmodule

`default_nettype wire

>>> hdl/mrr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mrr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_reg_value,
   input wire logic [7:0]  rsp_exception_code,
   input wire logic [7:0]  rsp_frame_length
);
   import mrr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_length))
      else $error("result changed while stalled");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled result");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_frame_length == FRAME_LEN_CNT)
      else $error("ok result with wrong frame length");

   a_short_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_length < MIN_LEN_CNT |-> rsp_status == ST_INCOMPLETE)
      else $error("short frame not flagged incomplete");

   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_reg_value == 32'h0)
         && (rsp_status == ST_EXCEPTION || rsp_exception_code == 8'h00))
      else $error("unused result field not zero");

endmodule

bind modbus_rtu_response_receiver mrr_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_reg_value      (rsp_reg_value),
   .rsp_exception_code (rsp_exception_code),
   .rsp_frame_length   (rsp_frame_length)
);

`default_nettype wire
